// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while rst is true.
`define ESC_ASSERT(lbl, clk, rst, prop) \
    lbl: assert property (@(posedge clk) disable iff (rst) prop) \
        else $error("esc assertion failed");

// Signal carries no X or Z on the rising clock edge, disabled while rst is true.
`define ESC_ASSERT_KNOWN(lbl, clk, rst, sig) \
    lbl: assert property (@(posedge clk) disable iff (rst) !$isunknown(sig)) \
        else $error("esc signal unknown");

`endif

// File: hdl/esc_pkg.sv
// Types and constants of the environmental sensor compensation block.
package esc_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_P9 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMID    = 3'd4;

    typedef struct packed {
        logic [31:0] temp;
        logic        guard;
        logic [31:0] xx;
        logic [31:0] ss;
    } t_side;

endpackage

// File: hdl/esc_ifs.sv
// Channel interfaces: raw sample input, compensated result output, configuration write.
interface esc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
    modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
    modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface esc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
    logic               pressure_div_guard;
    modport source (output valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                    pressure_div_guard, input ready);
    modport sink (input valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                  pressure_div_guard, output ready);
endinterface

interface esc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/esc_div.sv
// Pipelined unsigned 64-bit restoring divider, one quotient bit per stage.
module esc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [63:0]    i_num,
    input  logic [63:0]    i_den,
    input  logic           i_neg,
    input  esc_pkg::t_side i_side,
    output logic           o_valid,
    output logic [63:0]    o_quo,
    output logic           o_neg,
    output esc_pkg::t_side o_side
);
    localparam int Steps = 64;

    logic           r_vld  [0:Steps-1];
    logic [63:0]    r_rem  [0:Steps-1];
    logic [63:0]    r_dvd  [0:Steps-1];
    logic [63:0]    r_den  [0:Steps-1];
    logic           r_neg  [0:Steps-1];
    esc_pkg::t_side r_side [0:Steps-1];

    for (genvar k = 0; k < Steps; k++) begin : g_step
        logic           c_v;
        logic           c_n;
        logic [63:0]    c_rem;
        logic [63:0]    c_dvd;
        logic [63:0]    c_den;
        esc_pkg::t_side c_s;
        logic [64:0]    c_trial;

        if (k == 0) begin : g_first
            assign c_v   = i_valid;
            assign c_n   = i_neg;
            assign c_rem = '0;
            assign c_dvd = i_num;
            assign c_den = i_den;
            assign c_s   = i_side;
        end else begin : g_next
            assign c_v   = r_vld[k-1];
            assign c_n   = r_neg[k-1];
            assign c_rem = r_rem[k-1];
            assign c_dvd = r_dvd[k-1];
            assign c_den = r_den[k-1];
            assign c_s   = r_side[k-1];
        end

        assign c_trial = {c_rem, c_dvd[63]} - {1'b0, c_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= c_trial[64] ? {c_rem[62:0], c_dvd[63]} : c_trial[63:0];
                r_dvd[k]  <= {c_dvd[62:0], ~c_trial[64]};
                r_den[k]  <= c_den;
                r_neg[k]  <= c_n;
                r_side[k] <= c_s;
            end
        end
    end

    assign o_valid = r_vld[Steps-1];
    assign o_quo   = r_dvd[Steps-1];
    assign o_neg   = r_neg[Steps-1];
    assign o_side  = r_side[Steps-1];

endmodule

// File: hdl/environmental_sensor_compensation.sv
// Environmental sensor compensation top level: temperature, pressure and humidity pipeline.
//
// One raw sample set is taken per clock while the output is free or being
// taken. The 64-stage pressure divider sits between the coefficient stages
// and the pressure correction stages. A held output stalls the whole
// pipeline, so nothing is dropped. Configuration writes are always ready and
// take effect at once; write them only while no transaction is in flight.
`include "assert_macros.svh"

module environmental_sensor_compensation (
    input  logic            i_clk,
    input  logic            i_rst_n,
    esc_in_if.sink          i_in,
    esc_out_if.source       o_out,
    esc_cfg_if.sink         i_cfg
);
    localparam logic signed [31:0] HumMax = 32'sd419430400;

    logic [47:0] r_temp;
    logic [63:0] r_pa;
    logic [63:0] r_pb;
    logic [15:0] r_p9;
    logic [63:0] r_hum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp <= '0;
            r_pa   <= '0;
            r_pb   <= '0;
            r_p9   <= '0;
            r_hum  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                esc_pkg::CFG_TEMP:     r_temp <= i_cfg.data[47:0];
                esc_pkg::CFG_PRESS_A:  r_pa   <= i_cfg.data;
                esc_pkg::CFG_PRESS_B:  r_pb   <= i_cfg.data;
                esc_pkg::CFG_PRESS_P9: r_p9   <= i_cfg.data[15:0];
                esc_pkg::CFG_HUMID:    r_hum  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    logic signed [31:0] t1, t2, t3;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] h1, h2, h3, h4, h5, h6;

    assign t1 = {16'b0, r_temp[15:0]};
    assign t2 = {{16{r_temp[31]}}, r_temp[31:16]};
    assign t3 = {{16{r_temp[47]}}, r_temp[47:32]};
    assign p1 = {48'b0, r_pa[15:0]};
    assign p2 = {{48{r_pa[31]}}, r_pa[31:16]};
    assign p3 = {{48{r_pa[47]}}, r_pa[47:32]};
    assign p4 = {{48{r_pa[63]}}, r_pa[63:48]};
    assign p5 = {{48{r_pb[15]}}, r_pb[15:0]};
    assign p6 = {{48{r_pb[31]}}, r_pb[31:16]};
    assign p7 = {{48{r_pb[47]}}, r_pb[47:32]};
    assign p8 = {{48{r_pb[63]}}, r_pb[63:48]};
    assign p9 = {{48{r_p9[15]}}, r_p9};
    assign h1 = {24'b0, r_hum[7:0]};
    assign h2 = {{16{r_hum[23]}}, r_hum[23:8]};
    assign h3 = {24'b0, r_hum[31:24]};
    assign h4 = {{20{r_hum[43]}}, r_hum[43:32]};
    assign h5 = {{20{r_hum[55]}}, r_hum[55:44]};
    assign h6 = {{24{r_hum[63]}}, r_hum[63:56]};

    logic en;
    logic r18_v;

    assign en         = !r18_v || o_out.ready;
    assign i_in.ready = en;

    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v, r10_v, r11_v, r12_v;
    logic r13_v, r14_v, r15_v, r16_v, r17_v;

    logic [19:0] r1_rt, r1_rp, r2_rp, r3_rp, r4_rp, r5_rp, r6_rp, r7_rp, r8_rp, r9_rp, r10_rp;
    logic [15:0] r1_rh, r2_rh, r3_rh, r4_rh, r5_rh, r6_rh;
    logic signed [31:0] r2_a, r2_d, r3_m1, r3_dd, r4_var1, r4_m2, r5_tf;
    logic signed [31:0] r6_temp, r7_temp, r8_temp, r9_temp, r10_temp, r11_temp, r12_temp;
    logic signed [32:0] r6_w1;
    logic signed [31:0] r6_x;
    logic signed [63:0] r7_sq, r7_w1p5, r7_w1p2;
    logic signed [31:0] r7_hx5, r7_xh6, r7_xh3, r7_lpre;
    logic signed [63:0] r8_t6, r8_t3, r8_w1p5, r8_w1p2;
    logic signed [31:0] r8_left, r8_ra, r8_rb;
    logic signed [63:0] r9_w2, r9_w1b;
    logic signed [31:0] r9_rc, r9_left;
    logic signed [63:0] r10_m, r10_w2;
    logic signed [31:0] r10_rm, r10_left;
    logic signed [63:0] r11_dv, r11_num;
    logic signed [31:0] r11_xx;
    logic [63:0] r12_ua, r12_ub;
    logic r12_neg, r12_guard;
    logic signed [31:0] r12_ss, r12_xx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0; r2_v  <= 1'b0; r3_v  <= 1'b0; r4_v  <= 1'b0;
            r5_v  <= 1'b0; r6_v  <= 1'b0; r7_v  <= 1'b0; r8_v  <= 1'b0;
            r9_v  <= 1'b0; r10_v <= 1'b0; r11_v <= 1'b0; r12_v <= 1'b0;
        end else if (en) begin
            r1_v  <= i_in.valid; r2_v  <= r1_v;  r3_v  <= r2_v;  r4_v  <= r3_v;
            r5_v  <= r4_v;  r6_v  <= r5_v;  r7_v  <= r6_v;  r8_v  <= r7_v;
            r9_v  <= r8_v;  r10_v <= r9_v;  r11_v <= r10_v; r12_v <= r11_v;
        end
    end

    logic signed [63:0] c_pbase;
    logic signed [31:0] c_ss;

    assign c_pbase = 64'sd1048576 - $signed({44'b0, r10_rp});
    assign c_ss    = r11_xx >>> 15;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_rt <= i_in.raw_temperature;
            r1_rp <= i_in.raw_pressure;
            r1_rh <= i_in.raw_humidity;

            r2_a  <= $signed({15'b0, r1_rt[19:3]}) - (t1 <<< 1);
            r2_d  <= $signed({16'b0, r1_rt[19:4]}) - t1;
            r2_rp <= r1_rp;
            r2_rh <= r1_rh;

            r3_m1 <= r2_a * t2;
            r3_dd <= r2_d * r2_d;
            r3_rp <= r2_rp;
            r3_rh <= r2_rh;

            r4_var1 <= r3_m1 >>> 11;
            r4_m2   <= (r3_dd >>> 12) * t3;
            r4_rp   <= r3_rp;
            r4_rh   <= r3_rh;

            r5_tf <= r4_var1 + (r4_m2 >>> 14);
            r5_rp <= r4_rp;
            r5_rh <= r4_rh;

            r6_temp <= (r5_tf * 32'sd5 + 32'sd128) >>> 8;
            r6_w1   <= $signed({r5_tf[31], r5_tf}) - 33'sd128000;
            r6_x    <= r5_tf - 32'sd76800;
            r6_rp   <= r5_rp;
            r6_rh   <= r5_rh;

            r7_sq   <= 64'(r6_w1) * 64'(r6_w1);
            r7_w1p5 <= 64'(r6_w1) * p5;
            r7_w1p2 <= 64'(r6_w1) * p2;
            r7_hx5  <= h5 * r6_x;
            r7_xh6  <= r6_x * h6;
            r7_xh3  <= r6_x * h3;
            r7_lpre <= $signed({2'b0, r6_rh, 14'b0}) - (h4 <<< 20) + 32'sd16384;
            r7_rp   <= r6_rp;
            r7_temp <= r6_temp;

            r8_t6   <= r7_sq * p6;
            r8_t3   <= r7_sq * p3;
            r8_w1p5 <= r7_w1p5;
            r8_w1p2 <= r7_w1p2;
            r8_left <= (r7_lpre - r7_hx5) >>> 15;
            r8_ra   <= r7_xh6 >>> 10;
            r8_rb   <= (r7_xh3 >>> 11) + 32'sd32768;
            r8_rp   <= r7_rp;
            r8_temp <= r7_temp;

            r9_w2   <= r8_t6 + (r8_w1p5 <<< 17) + (p4 <<< 35);
            r9_w1b  <= (r8_t3 >>> 8) + (r8_w1p2 <<< 12);
            r9_rc   <= r8_ra * r8_rb;
            r9_left <= r8_left;
            r9_rp   <= r8_rp;
            r9_temp <= r8_temp;

            r10_m    <= (64'sh0000_8000_0000_0000 + r9_w1b) * p1;
            r10_w2   <= r9_w2;
            r10_rm   <= ((r9_rc >>> 10) + 32'sd2097152) * h2;
            r10_left <= r9_left;
            r10_rp   <= r9_rp;
            r10_temp <= r9_temp;

            r11_dv   <= r10_m >>> 33;
            r11_num  <= ((c_pbase <<< 31) - r10_w2) * 64'sd3125;
            r11_xx   <= r10_left * ((r10_rm + 32'sd8192) >>> 14);
            r11_temp <= r10_temp;

            r12_ua    <= r11_num[63] ? 64'(-r11_num) : r11_num;
            r12_ub    <= r11_dv[63] ? 64'(-r11_dv) : r11_dv;
            r12_neg   <= r11_num[63] ^ r11_dv[63];
            r12_guard <= (r11_dv == 64'sd0);
            r12_ss    <= c_ss * c_ss;
            r12_xx    <= r11_xx;
            r12_temp  <= r11_temp;
        end
    end

    esc_pkg::t_side c_side_in;
    esc_pkg::t_side d_side;
    logic           d_v;
    logic [63:0]    d_quo;
    logic           d_neg;

    assign c_side_in.temp  = r12_temp;
    assign c_side_in.guard = r12_guard;
    assign c_side_in.xx    = r12_xx;
    assign c_side_in.ss    = r12_ss;

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r12_v),
        .i_num   (r12_ua),
        .i_den   (r12_ub),
        .i_neg   (r12_neg),
        .i_side  (c_side_in),
        .o_valid (d_v),
        .o_quo   (d_quo),
        .o_neg   (d_neg),
        .o_side  (d_side)
    );

    logic signed [63:0] r13_p, r14_p, r14_q, r14_pp9, r14_e2m;
    logic signed [63:0] r15_p, r15_e2m, r16_p, r16_e2m, r16_prod, r17_sum;
    logic [63:0] r15_ll;
    logic [31:0] r15_lh, r15_hl;
    esc_pkg::t_side r13_side;
    logic signed [31:0] r14_sh, r14_xx;
    logic [31:0] r14_temp, r15_temp, r16_temp, r17_temp, r18_temp;
    logic r14_guard, r15_guard, r16_guard, r17_guard, r18_guard;
    logic [16:0] r15_hum, r16_hum, r17_hum, r18_hum;
    logic [31:0] r18_press;

    logic signed [31:0] c_x2;
    logic signed [31:0] c_xc;
    logic signed [63:0] c_press;

    assign c_x2    = r14_xx - (r14_sh >>> 4);
    assign c_xc    = c_x2[31] ? 32'sd0 : ((c_x2 > HumMax) ? HumMax : c_x2);
    assign c_press = (r17_sum >>> 8) + (p7 <<< 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r13_v <= 1'b0; r14_v <= 1'b0; r15_v <= 1'b0;
            r16_v <= 1'b0; r17_v <= 1'b0; r18_v <= 1'b0;
        end else if (en) begin
            r13_v <= d_v;   r14_v <= r13_v; r15_v <= r14_v;
            r16_v <= r15_v; r17_v <= r16_v; r18_v <= r17_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r13_p    <= d_neg ? $signed(64'(-d_quo)) : $signed(d_quo);
            r13_side <= d_side;

            r14_q     <= r13_p >>> 13;
            r14_pp9   <= p9 * (r13_p >>> 13);
            r14_e2m   <= p8 * r13_p;
            r14_p     <= r13_p;
            r14_sh    <= ($signed(r13_side.ss) >>> 7) * h1;
            r14_xx    <= $signed(r13_side.xx);
            r14_temp  <= r13_side.temp;
            r14_guard <= r13_side.guard;

            r15_ll    <= {32'b0, r14_pp9[31:0]} * {32'b0, r14_q[31:0]};
            r15_lh    <= r14_pp9[31:0] * r14_q[63:32];
            r15_hl    <= r14_pp9[63:32] * r14_q[31:0];
            r15_hum   <= c_xc[28:12];
            r15_p     <= r14_p;
            r15_e2m   <= r14_e2m;
            r15_temp  <= r14_temp;
            r15_guard <= r14_guard;

            r16_prod  <= $signed(r15_ll + {r15_lh + r15_hl, 32'b0});
            r16_p     <= r15_p;
            r16_e2m   <= r15_e2m;
            r16_hum   <= r15_hum;
            r16_temp  <= r15_temp;
            r16_guard <= r15_guard;

            r17_sum   <= r16_p + (r16_prod >>> 25) + (r16_e2m >>> 19);
            r17_hum   <= r16_hum;
            r17_temp  <= r16_temp;
            r17_guard <= r16_guard;

            r18_press <= r17_guard ? 32'd0 : c_press[31:0];
            r18_hum   <= r17_hum;
            r18_temp  <= r17_temp;
            r18_guard <= r17_guard;
        end
    end

    assign o_out.valid              = r18_v;
    assign o_out.temperature_centi  = $signed(r18_temp);
    assign o_out.pressure_q24_8     = r18_press;
    assign o_out.humidity_q22_10    = r18_hum;
    assign o_out.pressure_div_guard = r18_guard;

    `ESC_ASSERT(a_guard_zero, i_clk, !i_rst_n, o_out.valid && o_out.pressure_div_guard |-> o_out.pressure_q24_8 == 32'd0)
    `ESC_ASSERT(a_hum_clamp, i_clk, !i_rst_n, o_out.valid |-> o_out.humidity_q22_10 <= 17'd102400)
    `ESC_ASSERT(a_div_guard, i_clk, !i_rst_n, r12_v |-> ((r12_ub == 64'd0) == r12_guard))
    `ESC_ASSERT_KNOWN(a_out_valid_known, i_clk, !i_rst_n, o_out.valid)

endmodule

// File: sim/testbench.sv
// Self-checking testbench for environmental_sensor_compensation: table-driven and random samples.
module testbench;

    localparam logic [esc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [esc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic signed [31:0] temp;
        logic [31:0]        press;
        logic [16:0]        humid;
        logic               guard;
    } comp_t;

    typedef struct {
        logic [19:0] rt;
        logic [19:0] rp;
        logic [15:0] rh;
        bit          fixed;
        comp_t       res;
    } sample_row_t;

    logic i_clk;
    logic i_rst_n;
    esc_in_if  in_ch();
    esc_out_if out_ch();
    esc_cfg_if cfg_ch();

    environmental_sensor_compensation uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    logic [47:0] cf_temp;
    logic [63:0] cf_press_a;
    logic [63:0] cf_press_b;
    logic [15:0] cf_p9;
    logic [63:0] cf_humid;

    comp_t expected_q[$];
    int    n_fail;
    int    cycles;
    int    burst_left;
    int    stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] sdiv(logic signed [63:0] a, logic signed [63:0] b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        q = ua / ub;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic comp_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
        comp_t r;
        logic signed [31:0] t1, t2, t3, a, d, v1, v2, tf, prod;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] w1, w2, num, p, q, e1, e2, sum;
        logic signed [31:0] h1, h2, h3, h4, h5, h6, x, lft, rgt, s, u, hv;
        t1 = {16'd0, cf_temp[15:0]};
        t2 = {{16{cf_temp[31]}}, cf_temp[31:16]};
        t3 = {{16{cf_temp[47]}}, cf_temp[47:32]};
        a = {15'd0, rt[19:3]} - (t1 <<< 1);
        d = {16'd0, rt[19:4]} - t1;
        prod = a * t2;
        v1 = prod >>> 11;
        prod = d * d;
        prod = prod >>> 12;
        prod = prod * t3;
        v2 = prod >>> 14;
        tf = v1 + v2;
        prod = tf * 32'sd5 + 32'sd128;
        r.temp = prod >>> 8;

        p1 = {48'd0, cf_press_a[15:0]};
        p2 = {{48{cf_press_a[31]}}, cf_press_a[31:16]};
        p3 = {{48{cf_press_a[47]}}, cf_press_a[47:32]};
        p4 = {{48{cf_press_a[63]}}, cf_press_a[63:48]};
        p5 = {{48{cf_press_b[15]}}, cf_press_b[15:0]};
        p6 = {{48{cf_press_b[31]}}, cf_press_b[31:16]};
        p7 = {{48{cf_press_b[47]}}, cf_press_b[47:32]};
        p8 = {{48{cf_press_b[63]}}, cf_press_b[63:48]};
        p9 = {{48{cf_p9[15]}}, cf_p9};
        w1 = {{32{tf[31]}}, tf} - 64'sd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) <<< 17);
        w2 = w2 + (p4 <<< 35);
        num = w1 * w1 * p3;
        w1 = (num >>> 8) + ((w1 * p2) <<< 12);
        num = ((64'sd1 <<< 47) + w1) * p1;
        w1 = num >>> 33;
        r.guard = (w1 == 64'sd0);
        r.press = '0;
        if (!r.guard) begin
            p = 64'sd1048576 - {44'd0, rp};
            num = ((p <<< 31) - w2) * 64'sd3125;
            p = sdiv(num, w1);
            q = p >>> 13;
            e1 = p9 * q * q;
            e1 = e1 >>> 25;
            e2 = p8 * p;
            e2 = e2 >>> 19;
            sum = p + e1 + e2;
            sum = (sum >>> 8) + (p7 <<< 4);
            r.press = sum[31:0];
        end

        h1 = {24'd0, cf_humid[7:0]};
        h2 = {{16{cf_humid[23]}}, cf_humid[23:8]};
        h3 = {24'd0, cf_humid[31:24]};
        h4 = {{20{cf_humid[43]}}, cf_humid[43:32]};
        h5 = {{20{cf_humid[55]}}, cf_humid[55:44]};
        h6 = {{24{cf_humid[63]}}, cf_humid[63:56]};
        x = tf - 32'sd76800;
        u = ({16'd0, rh} <<< 14) - (h4 <<< 20) - h5 * x + 32'sd16384;
        lft = u >>> 15;
        u = x * h6;
        u = u >>> 10;
        hv = x * h3;
        hv = (hv >>> 11) + 32'sd32768;
        u = u * hv;
        rgt = (u >>> 10) + 32'sd2097152;
        u = rgt * h2 + 32'sd8192;
        rgt = u >>> 14;
        x = lft * rgt;
        s = x >>> 15;
        u = s * s;
        u = u >>> 7;
        u = u * h1;
        x = x - (u >>> 4);
        if (x < 0)
            x = 0;
        else if (x > 32'sd419430400)
            x = 32'sd419430400;
        r.humid = x[28:12];
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("environmental_sensor_compensation regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (cycles % 250 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= (cycles % 7 != 3) && (cycles % 11 != 5);
            default: out_ch.ready <= ($urandom_range(0, 9) > 3);
        endcase
    end

    always @(posedge i_clk) begin
        comp_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                $error("result with no pending sample");
                n_fail++;
            end else begin
                e = expected_q.pop_front();
                if (out_ch.temperature_centi !== e.temp) begin
                    $error("temperature_centi expected %0d got %0d", e.temp,
                           out_ch.temperature_centi);
                    n_fail++;
                end
                if (out_ch.pressure_q24_8 !== e.press) begin
                    $error("pressure_q24_8 expected %0h got %0h", e.press,
                           out_ch.pressure_q24_8);
                    n_fail++;
                end
                if (out_ch.humidity_q22_10 !== e.humid) begin
                    $error("humidity_q22_10 expected %0d got %0d", e.humid,
                           out_ch.humidity_q22_10);
                    n_fail++;
                end
                if (out_ch.pressure_div_guard !== e.guard) begin
                    $error("pressure_div_guard expected %0b got %0b", e.guard,
                           out_ch.pressure_div_guard);
                    n_fail++;
                end
            end
        end
    end

    task automatic write_reg(logic [esc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            esc_pkg::CFG_TEMP:     cf_temp    = val[47:0];
            esc_pkg::CFG_PRESS_A:  cf_press_a = val;
            esc_pkg::CFG_PRESS_B:  cf_press_b = val;
            esc_pkg::CFG_PRESS_P9: cf_p9      = val[15:0];
            esc_pkg::CFG_HUMID:    cf_humid   = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        wait (expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_coeffs(logic [63:0] t, logic [63:0] pa, logic [63:0] pb,
                               logic [63:0] p9, logic [63:0] h);
        drain();
        write_reg(esc_pkg::CFG_TEMP, t);
        write_reg(esc_pkg::CFG_PRESS_A, pa);
        write_reg(esc_pkg::CFG_PRESS_B, pb);
        write_reg(esc_pkg::CFG_PRESS_P9, p9);
        write_reg(esc_pkg::CFG_HUMID, h);
    endtask

    task automatic send_sample(sample_row_t row);
        if (burst_left == 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end else begin
            @(negedge i_clk);
        end
        burst_left--;
        in_ch.valid           <= 1'b1;
        in_ch.raw_temperature <= row.rt;
        in_ch.raw_pressure    <= row.rp;
        in_ch.raw_humidity    <= row.rh;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_q.push_back(row.fixed ? row.res : compensate(row.rt, row.rp, row.rh));
    endtask

    task automatic random_samples(int n);
        sample_row_t row;
        repeat (n) begin
            row.fixed = 1'b0;
            if ($urandom_range(0, 1)) begin
                row.rt = 20'($urandom_range(0, 20'hFFFFF));
                row.rp = 20'($urandom_range(0, 20'hFFFFF));
                row.rh = 16'($urandom_range(0, 16'hFFFF));
            end else begin
                row.rt = 20'($urandom_range(380000, 620000));
                row.rp = 20'($urandom_range(250000, 480000));
                row.rh = 16'($urandom_range(20000, 45000));
            end
            send_sample(row);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    sample_row_t directed[$];

    initial begin
        n_fail = 0;
        cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        cf_temp = '0;
        cf_press_a = '0;
        cf_press_b = '0;
        cf_p9 = '0;
        cf_humid = '0;
        in_ch.valid = 1'b0;
        in_ch.raw_temperature = '0;
        in_ch.raw_pressure = '0;
        in_ch.raw_humidity = '0;
        out_ch.ready = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // all-zero coefficients: zero divisor, everything else collapses to 0
        directed = '{
            '{20'h00000, 20'h00000, 16'h0000, 1'b1, '{32'sd0, 32'd0, 17'd0, 1'b1}},
            '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, '{32'sd0, 32'd0, 17'd0, 1'b1}},
            '{20'hAAAAA, 20'h55555, 16'hA5A5, 1'b1, '{32'sd0, 32'd0, 17'd0, 1'b1}},
            '{20'h55555, 20'hAAAAA, 16'h5A5A, 1'b1, '{32'sd0, 32'd0, 17'd0, 1'b1}}
        };
        foreach (directed[i]) send_sample(directed[i]);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        // typical calibration, extremes of the raw readings
        load_coeffs(64'hFFFF_FC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D,
                    64'hC6F8_3C8C_FFF9_008C, 64'd6000, 64'h1E00_0144_0001_6A4B);
        directed = '{
            '{20'h00000, 20'h00000, 16'h0000, 1'b0, '{32'sd0, 32'd0, 17'd0, 1'b0}},
            '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, '{32'sd0, 32'd0, 17'd0, 1'b0}},
            '{20'h7EED0, 20'h5A3C0, 16'h6E00, 1'b0, '{32'sd0, 32'd0, 17'd0, 1'b0}},
            '{20'h00000, 20'hFFFFF, 16'hFFFF, 1'b0, '{32'sd0, 32'd0, 17'd0, 1'b0}},
            '{20'hFFFFF, 20'h00000, 16'h0000, 1'b0, '{32'sd0, 32'd0, 17'd0, 1'b0}},
            '{20'h80000, 20'h80000, 16'h8000, 1'b0, '{32'sd0, 32'd0, 17'd0, 1'b0}}
        };
        foreach (directed[i]) send_sample(directed[i]);
        random_samples(200);

        // out-of-range writes are dropped
        drain();
        write_reg(CFG_UNUSED_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_UNUSED_HI, 64'h1234_5678_9ABC_DEF0);
        random_samples(100);

        // zero P1 with live coefficients: divisor guard
        load_coeffs(64'hABCD_FC18_6743_6B70, 64'h0B27_0BD0_D643_0000,
                    64'hC6F8_3C8C_FFF9_008C, 64'hFFFF_FFFF_FFFF_E890,
                    64'h1E00_0144_4B01_6A4B);
        random_samples(100);

        // all ones
        load_coeffs('1, '1, '1, '1, '1);
        random_samples(150);

        // most negative signed fields
        load_coeffs(64'h0000_8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
                    64'h8000_8000_8000_8000, 64'h8000, 64'h8080_0800_FF80_00FF);
        random_samples(150);

        // most positive signed fields
        load_coeffs(64'h0000_7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_0001,
                    64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF, 64'h7F7F_F7FF_007F_FF01);
        random_samples(150);

        repeat (4) begin
            load_coeffs({$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
            random_samples(70);
        end

        drain();
        if (n_fail == 0 && expected_q.size() == 0)
            $display("environmental_sensor_compensation regression: pass");
        else
            $display("environmental_sensor_compensation regression: fail");
        $finish;
    end
endmodule

// File: environmental_sensor_compensation.f
+incdir+hdl
hdl/esc_pkg.sv
hdl/esc_ifs.sv
hdl/esc_div.sv
hdl/environmental_sensor_compensation.sv
sim/testbench.sv
